### rtl/c2s_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared types, constants, the CORDIC step function and the angle rounding
// function for the cartesian to spherical CORDIC pipeline.
// ----------------------------------------------------------------------------
package c2s_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TBL_LEN = 24;

  // vector datapath width (Q8) and angle accumulator width (degrees, Q16)
  localparam int VW = 27;
  localparam int AW = 26;
  // gain product width
  localparam int PW = VW + 33;

  localparam int ATAN_W = 22;
  localparam logic [ATAN_W-1:0] ATAN_TBL [TBL_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0
  };

  localparam logic signed [AW-1:0] HALF_TURN = 26'sd11796480;
  localparam logic signed [AW-1:0] ANG_RND   = 26'sd256;
  localparam logic signed [AW-1:0] AZ_LIMIT  = 26'sd23040;
  localparam logic signed [AW-1:0] EL_LIMIT  = 26'sd11520;

  localparam logic signed [32:0] INV_GAIN = 33'sd2608131496;
  // half lsb at 2^-32 for the gain fix
  localparam logic signed [PW-1:0] RND_GAIN = PW'(64'sd2147483648);
  // gain fix rounding folded with the range rounding, both at 2^-40
  localparam logic signed [PW-1:0] RND_LEN = PW'(64'sd551903297536);

  localparam logic signed [PW-1:0] LEN_MAX = PW'(64'sd65535);

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [AW-1:0] a;
  } cordic_t;

  // pass one side information
  typedef struct packed {
    logic signed [15:0] z;
    logic               xy_zero;
    logic               xyz_zero;
  } sb1_t;

  // pass two side information
  typedef struct packed {
    logic signed [15:0] az;
    logic               xyz_zero;
  } sb2_t;

  function automatic cordic_t cordic_step(cordic_t s, logic [4:0] idx);
    cordic_t              o;
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;
    logic signed [AW-1:0] da;
    dx = s.y >>> idx;
    dy = s.x >>> idx;
    da = signed'({{(AW-ATAN_W){1'b0}}, ATAN_TBL[idx]});
    if (!s.y[VW-1]) begin
      o.x = s.x + dx;
      o.y = s.y - dy;
      o.a = s.a + da;
    end else begin
      o.x = s.x - dx;
      o.y = s.y + dy;
      o.a = s.a - da;
    end
    return o;
  endfunction

  // round half up to 7 fraction bits, then clamp to +/- lim
  function automatic logic signed [AW-1:0] angle_round(logic signed [AW-1:0] acc,
                                                        logic signed [AW-1:0] lim);
    logic signed [AW-1:0] q;
    q = (acc + ANG_RND) >>> 9;
    if (q > lim) begin
      q = lim;
    end else if (q < -lim) begin
      q = -lim;
    end
    return q;
  endfunction

endpackage

### rtl/cartesian_to_spherical.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// Converts a signed 16-bit point (x, y, z) to azimuth, elevation and range
// using two chained CORDIC vectoring passes in a fully pipelined datapath.
//
// Usage:
//   Input channel  in_valid / in_ready carries x, y, z. Result channel
//   out_valid / out_ready carries azimuth and elevation (degrees * 128)
//   and the rounded range. Every transfer in gives exactly one transfer out.
//   The pipeline is an input register, one register per CORDIC iteration
//   in each pass, a gain multiply and a rounding stage between the passes,
//   a gain multiply after pass two and the output register.
//   Throughput is one point per cycle unless the receiver stalls; each
//   gain multiplier is its own pipeline stage.
//   Reset clears all valid bits; no result is presented afterwards until
//   new points arrive. When the receiver stalls with a result waiting, the
//   whole pipeline holds and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module cartesian_to_spherical
  import c2s_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_x_coord,
  input  logic signed [15:0] in_y_coord,
  input  logic signed [15:0] in_z_coord,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_azimuth_deg,
  output logic signed [14:0] out_elevation_deg,
  output logic        [15:0] out_range_len
);

  localparam int N     = CORDIC_STAGES;
  localparam int DEPTH = 2 * N + 5;

  logic                 en;
  logic [DEPTH-1:0]     valid_r;

  cordic_t              p1_r [0:N];
  sb1_t                 sb1_r [0:N];
  cordic_t              p2_r [0:N];
  sb2_t                 sb2_r [0:N];

  cordic_t              p1_nxt;
  sb1_t                 sb1_nxt;
  cordic_t              p2_nxt;
  sb2_t                 sb2_nxt;

  logic signed [PW-1:0] g1_prod_r;
  logic signed [AW-1:0] g1_acc_r;
  sb1_t                 g1_sb_r;
  logic signed [PW-1:0] g1_prod_nxt;

  logic signed [PW-1:0] g2_prod_r;
  logic signed [AW-1:0] g2_acc_r;
  sb2_t                 g2_sb_r;
  logic signed [PW-1:0] g2_prod_nxt;

  logic signed [VW-1:0] x_ext;
  logic signed [VW-1:0] y_ext;
  logic signed [PW-1:0] h_full;
  logic signed [PW-1:0] len_q;

  logic signed [15:0]   az_r;
  logic signed [14:0]   el_r;
  logic        [15:0]   len_r;
  logic signed [15:0]   az_nxt;
  logic signed [14:0]   el_nxt;
  logic        [15:0]   len_nxt;

  // pipeline advances unless a finished result is held by the receiver
  assign en       = ~valid_r[DEPTH-1] | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[DEPTH-2:0], in_valid};
    end
  end

  // input stage: fold the left half plane onto the right
  always_comb begin
    x_ext = {{(VW-24){in_x_coord[15]}}, in_x_coord, 8'b0};
    y_ext = {{(VW-24){in_y_coord[15]}}, in_y_coord, 8'b0};
    if (in_x_coord[15]) begin
      p1_nxt.x = -x_ext;
      p1_nxt.y = -y_ext;
      p1_nxt.a = in_y_coord[15] ? -HALF_TURN : HALF_TURN;
    end else begin
      p1_nxt.x = x_ext;
      p1_nxt.y = y_ext;
      p1_nxt.a = '0;
    end
    sb1_nxt.z        = in_z_coord;
    sb1_nxt.xy_zero  = (in_x_coord == '0) && (in_y_coord == '0);
    sb1_nxt.xyz_zero = sb1_nxt.xy_zero && (in_z_coord == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r[0]  <= p1_nxt;
      sb1_r[0] <= sb1_nxt;
    end
  end

  // pass one: azimuth
  for (genvar g = 0; g < N; g++) begin : g_pass1
    always_ff @(posedge clk) begin
      if (en) begin
        p1_r[g+1]  <= cordic_step(p1_r[g], 5'(g));
        sb1_r[g+1] <= sb1_r[g];
      end
    end
  end

  // gain fix of the horizontal length
  assign g1_prod_nxt = PW'(p1_r[N].x) * PW'(INV_GAIN);

  always_ff @(posedge clk) begin
    if (en) begin
      g1_prod_r <= g1_prod_nxt;
      g1_acc_r  <= p1_r[N].a;
      g1_sb_r   <= sb1_r[N];
    end
  end

  always_comb begin
    h_full   = (g1_prod_r + RND_GAIN) >>> 32;
    p2_nxt.x = VW'(h_full);
    p2_nxt.y = {{(VW-24){g1_sb_r.z[15]}}, g1_sb_r.z, 8'b0};
    p2_nxt.a = '0;
    sb2_nxt.az = g1_sb_r.xy_zero ? '0 : 16'(angle_round(g1_acc_r, AZ_LIMIT));
    sb2_nxt.xyz_zero = g1_sb_r.xyz_zero;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_r[0]  <= p2_nxt;
      sb2_r[0] <= sb2_nxt;
    end
  end

  // pass two: elevation and range
  for (genvar g = 0; g < N; g++) begin : g_pass2
    always_ff @(posedge clk) begin
      if (en) begin
        p2_r[g+1]  <= cordic_step(p2_r[g], 5'(g));
        sb2_r[g+1] <= sb2_r[g];
      end
    end
  end

  assign g2_prod_nxt = PW'(p2_r[N].x) * PW'(INV_GAIN);

  always_ff @(posedge clk) begin
    if (en) begin
      g2_prod_r <= g2_prod_nxt;
      g2_acc_r  <= p2_r[N].a;
      g2_sb_r   <= sb2_r[N];
    end
  end

  // output stage
  always_comb begin
    len_q  = (g2_prod_r + RND_LEN) >>> 40;
    az_nxt = g2_sb_r.az;
    el_nxt = g2_sb_r.xyz_zero ? '0 : 15'(angle_round(g2_acc_r, EL_LIMIT));
    priority if (g2_sb_r.xyz_zero || len_q < 0) begin
      len_nxt = '0;
    end else if (len_q > LEN_MAX) begin
      len_nxt = '1;
    end else begin
      len_nxt = 16'(len_q);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      az_r  <= az_nxt;
      el_r  <= el_nxt;
      len_r <= len_nxt;
    end
  end

  assign out_valid         = valid_r[DEPTH-1];
  assign out_azimuth_deg   = az_r;
  assign out_elevation_deg = el_r;
  assign out_range_len     = len_r;

  // stalled result must block new transfers in
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_azimuth_deg <= 16'sd23040) && (out_azimuth_deg >= -16'sd23040))
    else $error("azimuth out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_elevation_deg <= 15'sd11520) && (out_elevation_deg >= -15'sd11520))
    else $error("elevation out of range");

  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
